// ===== hw/rtl/ns3_pkg.sv =====
// ----------------------------------------------------------------------------
// ns3_pkg
// Shared constants, types and helpers of the 3x3 neighbour sum block.
// ----------------------------------------------------------------------------
package ns3_pkg;

    localparam int MAX_SIDE = 32;
    localparam int SAMPLE_W = 16;
    localparam int SIDE_W   = 6;
    localparam int POS_W    = 5;
    localparam int SUM_W    = 19;
    localparam int COLSUM_W = SAMPLE_W + 2;
    localparam int ACC_W    = SAMPLE_W + 4;
    localparam int DEPTH    = 3 * MAX_SIDE;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int SIDE_RST = 32;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [COLSUM_W-1:0] t_colsum;
    typedef logic signed [ACC_W-1:0]    t_acc;
    typedef logic signed [SUM_W-1:0]    t_nsum;
    typedef logic [SIDE_W-1:0]          t_side;
    typedef logic [POS_W-1:0]           t_pos;
    typedef logic [ADDR_W-1:0]          t_addr;
    typedef logic [1:0]                 t_slot;

    localparam t_slot SLOT_LAST = 2'd2;

    function automatic t_slot slot_prev(t_slot s);
        t_slot p;
        p = (s == '0) ? SLOT_LAST : s - 2'd1;
        return p;
    endfunction

    function automatic t_slot slot_next(t_slot s);
        t_slot p;
        p = (s == SLOT_LAST) ? '0 : s + 2'd1;
        return p;
    endfunction

    function automatic t_addr mem_addr(t_slot s, t_pos c);
        t_addr a;
        a = ADDR_W'(s) * ADDR_W'(MAX_SIDE) + ADDR_W'(c);
        return a;
    endfunction

endpackage

// ===== hw/rtl/ns3_in_if.sv =====
// ----------------------------------------------------------------------------
// ns3_in_if
// Sample input channel: valid/ready handshake with one sample per transfer.
// ----------------------------------------------------------------------------
interface ns3_in_if;
    import ns3_pkg::*;

    logic    valid;
    logic    ready;
    t_sample sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);

endinterface

// ===== hw/rtl/ns3_out_if.sv =====
// ----------------------------------------------------------------------------
// ns3_out_if
// Result channel: valid/ready handshake, one cell sum per transfer.
// ----------------------------------------------------------------------------
interface ns3_out_if;
    import ns3_pkg::*;

    logic  valid;
    logic  ready;
    t_nsum neighbour_sum;
    t_pos  cell_row;
    t_pos  cell_col;
    logic  run_last;
    logic  frame_done;

    modport source (output valid, output neighbour_sum, output cell_row, output cell_col,
                    output run_last, output frame_done, input ready);
    modport sink   (input valid, input neighbour_sum, input cell_row, input cell_col,
                    input run_last, input frame_done, output ready);

endinterface

// ===== hw/rtl/neighbour_sum_3x3.sv =====
// ----------------------------------------------------------------------------
// neighbour_sum_3x3
// When a sample completes a cell, its result goes through S_COL and S_EMIT to
// the output register; S_EMIT waits while that register is full. A right-edge
// cell follows through S_EDGE and S_EMIT. No new sample is taken before the
// block is back in S_IDLE. The last sample adds a flush of the last row, cell
// by cell through S_FRD and S_FCOL, via the line store read port.
// Reset (synchronous): frame position cleared, side length 32, no result.
// ----------------------------------------------------------------------------
module neighbour_sum_3x3 (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  ns3_pkg::t_side i_cfg_wdata,
    ns3_in_if.sink        i_smp,
    ns3_out_if.source     o_res
);
    import ns3_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_COL  = 6'b000010,
        S_EMIT = 6'b000100,
        S_EDGE = 6'b001000,
        S_FRD  = 6'b010000,
        S_FCOL = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    t_side   r_side;
    t_pos    r_row, r_col;
    t_slot   r_slot;
    logic    r_has_top, r_has_mid, r_edge_pend, r_flush_pend, r_flush;
    logic    r_ovalid;

    t_pos    r_it_row, r_it_col, r_fcol, r_cell_row, r_cell_col;
    t_slot   r_it_slot;
    t_sample r_sample;
    t_colsum r_sum_l, r_sum_m, r_sum_r;
    t_sample r_ctr_m, r_ctr_r;
    t_sample mem [DEPTH];
    t_sample r_rd_top, r_rd_mid;
    t_nsum   r_onsum;
    t_pos    r_orow, r_ocol;
    logic    r_olast, r_odone;

    t_side   side_eff, side_m1;
    logic    pos_ok, in_xfer, last_col, last_row, out_free, col_clear, do_shift;
    logic    emit_last, emit_done, cell_end;
    t_pos    acc_row, acc_col;
    t_slot   acc_slot;
    t_addr   wr_addr, rd_top_addr, rd_mid_addr;
    t_sample col_top, col_mid, col_bot;
    t_colsum col_sum;
    t_acc    cell_acc;

    always_comb begin
        if (r_side < SIDE_W'(2)) begin
            side_eff = SIDE_W'(2);
        end else if (r_side > SIDE_W'(MAX_SIDE)) begin
            side_eff = SIDE_W'(MAX_SIDE);
        end else begin
            side_eff = r_side;
        end
    end

    assign side_m1  = side_eff - SIDE_W'(1);
    assign pos_ok   = (SIDE_W'(r_row) < side_eff) && (SIDE_W'(r_col) < side_eff);
    assign acc_row  = pos_ok ? r_row : '0;
    assign acc_col  = pos_ok ? r_col : '0;
    assign acc_slot = pos_ok ? r_slot : '0;
    assign last_col = SIDE_W'(acc_col) == side_m1;
    assign last_row = SIDE_W'(acc_row) == side_m1;

    assign i_smp.ready = (r_state == S_IDLE);
    assign in_xfer     = i_smp.valid && i_smp.ready;
    assign out_free    = !r_ovalid || o_res.ready;
    assign cell_end    = SIDE_W'(r_cell_col) == side_m1;

    // line store: row r lives in slot r mod 3
    assign wr_addr = mem_addr(acc_slot, acc_col);

    always_comb begin
        if (r_state == S_IDLE) begin
            rd_top_addr = mem_addr(slot_prev(slot_prev(acc_slot)), acc_col);
            rd_mid_addr = mem_addr(slot_prev(acc_slot), acc_col);
        end else begin
            rd_top_addr = mem_addr(slot_prev(r_it_slot), r_fcol);
            rd_mid_addr = mem_addr(r_it_slot, r_fcol);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            mem[wr_addr] <= i_smp.sample;
        end
        r_rd_top <= mem[rd_top_addr];
        r_rd_mid <= mem[rd_mid_addr];
    end

    // incoming column of the 3x3 window
    always_comb begin
        if (r_state == S_FCOL) begin
            col_top   = r_rd_top;
            col_mid   = r_rd_mid;
            col_bot   = '0;
            col_clear = (r_fcol == '0);
        end else begin
            col_top   = r_has_top ? r_rd_top : '0;
            col_mid   = r_has_mid ? r_rd_mid : '0;
            col_bot   = r_sample;
            col_clear = (r_it_col == '0);
        end
    end

    assign col_sum  = COLSUM_W'(col_top) + COLSUM_W'(col_mid) + COLSUM_W'(col_bot);
    assign do_shift = (r_state == S_COL) || (r_state == S_FCOL);
    assign cell_acc = ACC_W'(r_sum_l) + ACC_W'(r_sum_m) - ACC_W'(r_ctr_m) + ACC_W'(r_sum_r);

    assign emit_last = r_flush ? cell_end : (!r_edge_pend && !r_flush_pend);
    assign emit_done = r_flush && cell_end;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_xfer) n_state = S_COL;
            end
            S_COL: begin
                n_state = (r_has_mid && r_it_col != '0) ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (out_free) begin
                    if (r_edge_pend) begin
                        n_state = S_EDGE;
                    end else if (r_flush) begin
                        n_state = cell_end ? S_IDLE : S_FRD;
                    end else if (r_flush_pend) begin
                        n_state = S_FRD;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EDGE: n_state = S_EMIT;
            S_FRD:  n_state = S_FCOL;
            S_FCOL: n_state = (r_fcol != '0) ? S_EMIT : S_FRD;
            default: n_state = S_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_side       <= SIDE_W'(SIDE_RST);
            r_row        <= '0;
            r_col        <= '0;
            r_slot       <= '0;
            r_has_top    <= 1'b0;
            r_has_mid    <= 1'b0;
            r_edge_pend  <= 1'b0;
            r_flush_pend <= 1'b0;
            r_flush      <= 1'b0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_EMIT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_res.ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_side <= i_cfg_wdata;
                r_row  <= '0;
                r_col  <= '0;
                r_slot <= '0;
            end else if (in_xfer) begin
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row  <= '0;
                        r_slot <= '0;
                    end else begin
                        r_row  <= acc_row + POS_W'(1);
                        r_slot <= slot_next(acc_slot);
                    end
                end else begin
                    r_row  <= acc_row;
                    r_slot <= acc_slot;
                    r_col  <= acc_col + POS_W'(1);
                end
            end
            case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_has_top    <= acc_row >= POS_W'(2);
                        r_has_mid    <= acc_row != '0;
                        r_edge_pend  <= (acc_row != '0) && last_col;
                        r_flush_pend <= last_row && last_col;
                        r_flush      <= 1'b0;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        if (!r_edge_pend && !r_flush && r_flush_pend) begin
                            r_flush      <= 1'b1;
                            r_flush_pend <= 1'b0;
                        end
                        if (!r_edge_pend && r_flush && cell_end) r_flush <= 1'b0;
                    end
                end
                S_EDGE: begin
                    r_edge_pend <= 1'b0;
                end
                S_FCOL: begin
                    if (SIDE_W'(r_fcol) == side_m1) r_edge_pend <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_it_row  <= acc_row;
            r_it_col  <= acc_col;
            r_it_slot <= acc_slot;
            r_sample  <= i_smp.sample;
        end
        if (do_shift) begin
            r_sum_l <= col_clear ? '0 : r_sum_m;
            r_sum_m <= col_clear ? '0 : r_sum_r;
            r_ctr_m <= col_clear ? '0 : r_ctr_r;
            r_sum_r <= col_sum;
            r_ctr_r <= col_mid;
        end
        case (r_state)
            S_COL: begin
                r_cell_row <= r_it_row - POS_W'(1);
                r_cell_col <= r_it_col - POS_W'(1);
            end
            S_EMIT: begin
                if (out_free) begin
                    r_onsum <= cell_acc[SUM_W-1:0];
                    r_orow  <= r_cell_row;
                    r_ocol  <= r_cell_col;
                    r_olast <= emit_last;
                    r_odone <= emit_done;
                    if (!r_edge_pend && !r_flush && r_flush_pend) r_fcol <= '0;
                end
            end
            S_EDGE: begin
                r_sum_l    <= r_sum_m;
                r_sum_m    <= r_sum_r;
                r_ctr_m    <= r_ctr_r;
                r_sum_r    <= '0;
                r_ctr_r    <= '0;
                r_cell_col <= r_cell_col + POS_W'(1);
            end
            S_FCOL: begin
                r_cell_row <= r_it_row;
                r_cell_col <= r_fcol - POS_W'(1);
                r_fcol     <= r_fcol + POS_W'(1);
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid         = r_ovalid;
    assign o_res.neighbour_sum = r_onsum;
    assign o_res.cell_row      = r_orow;
    assign o_res.cell_col      = r_ocol;
    assign o_res.run_last      = r_olast;
    assign o_res.frame_done    = r_odone;

endmodule

// ===== hw/rtl/ns3_chk.sv =====
// ----------------------------------------------------------------------------
// ns3_chk
// Port-level checks of neighbour_sum_3x3, bound to every instance of it.
// ----------------------------------------------------------------------------
module ns3_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input ns3_pkg::t_nsum i_nsum,
    input ns3_pkg::t_pos i_row,
    input ns3_pkg::t_pos i_col,
    input logic          i_last,
    input logic          i_done
);
    import ns3_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_nsum)
            && $stable(i_row) && $stable(i_col) && $stable(i_last) && $stable(i_done))
        else $error("stalled result changed");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input taken while previous sample in work");

    a_busy_mid_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_last |-> !i_in_ready)
        else $error("input ready with results of a sample still pending");

    a_done_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_done |-> i_last && (i_row == i_col))
        else $error("frame end not on the last corner cell");

endmodule

bind neighbour_sum_3x3 ns3_chk u_ns3_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_smp.valid),
    .i_in_ready  (i_smp.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_nsum      (o_res.neighbour_sum),
    .i_row       (o_res.cell_row),
    .i_col       (o_res.cell_col),
    .i_last      (o_res.run_last),
    .i_done      (o_res.frame_done)
);

// ===== tb/tb_neighbour_sum_3x3.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_neighbour_sum_3x3
// Self-checking bench for the 3x3 neighbour sum block. Frames of samples are
// streamed in at several side lengths. A behavioral model of the block's line
// store predicts each cell sum, its position and its end flags. Every result
// transfer is checked against the oldest prediction. A short directed table
// runs first; random frames with random gaps and stalls follow.
// ----------------------------------------------------------------------------
module tb_neighbour_sum_3x3;
    import ns3_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 16;
    localparam int DRAIN_CYCLES  = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_LIMIT    = 3000;
    localparam int RANDOM_ITEMS  = 120;

    typedef struct {
        t_nsum nsum;
        t_pos  row;
        t_pos  col;
        logic  run_last;
        logic  frame_done;
    } t_cell_res;

    typedef enum logic {STEP_CFG, STEP_SMP} t_step_kind;

    typedef struct packed {
        t_step_kind kind;
        int         value;
        int         reps;
        bit         typed;
        int         exp_sum;
    } t_step;

    localparam int PLAN_LEN = 12;

    logic   i_clk;
    logic   i_rst_n;
    logic   i_cfg_we;
    t_side  i_cfg_wdata;

    ns3_in_if  smp_if ();
    ns3_out_if res_if ();

    neighbour_sum_3x3 dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_smp       (smp_if),
        .o_res       (res_if)
    );

    // predictor state
    t_sample   window_rows [3][MAX_SIDE];
    int        pos_row;
    int        pos_col;
    t_side     side_reg;
    t_cell_res expected_cells [$];

    // tags riding along with the sample being offered
    bit        cur_typed;
    int        cur_typed_sum;

    bit        calm;
    bit        hold_req;
    int        err_count;
    int        idle_cycles;
    int        drv_side;
    t_step     plan [PLAN_LEN];

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int clamp_side(int v);
        if (v < 2) return 2;
        if (v > MAX_SIDE) return MAX_SIDE;
        return v;
    endfunction

    function automatic t_nsum cell_total(int r, int c, int n);
        int acc;
        int rr;
        int cc;
        acc = 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                rr = r + dr;
                cc = c + dc;
                if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < n && cc < n) begin
                    acc += window_rows[rr % 3][cc];
                end
            end
        end
        return t_nsum'(acc);
    endfunction

    function automatic t_cell_res make_cell(int r, int c, int n);
        t_cell_res entry;
        entry.nsum       = cell_total(r, c, n);
        entry.row        = t_pos'(r);
        entry.col        = t_pos'(c);
        entry.run_last   = 1'b0;
        entry.frame_done = 1'b0;
        return entry;
    endfunction

    function automatic void predict_cell_sums(t_sample v, bit typed, int tsum);
        t_cell_res batch [$];
        t_cell_res entry;
        int        n;
        int        r;
        int        c;
        bit        done;
        n    = clamp_side(int'(side_reg));
        r    = pos_row;
        c    = pos_col;
        done = 1'b0;
        if (r >= n || c >= n) begin
            r = 0;
            c = 0;
        end
        window_rows[r % 3][c] = v;
        if (r >= 1) begin
            if (c >= 1) batch.insert(batch.size(), make_cell(r - 1, c - 1, n));
            if (c == n - 1) batch.insert(batch.size(), make_cell(r - 1, c, n));
        end
        if (r == n - 1 && c == n - 1) begin
            for (int j = 0; j < n; j++) batch.insert(batch.size(), make_cell(r, j, n));
            done = 1'b1;
        end
        for (int k = 0; k < batch.size(); k++) begin
            entry = batch[k];
            entry.run_last   = (k == batch.size() - 1);
            entry.frame_done = done && (k == batch.size() - 1);
            if (typed) entry.nsum = t_nsum'(tsum);
            expected_cells.insert(expected_cells.size(), entry);
        end
        c++;
        if (c >= n) begin
            c = 0;
            r++;
            if (r >= n) r = 0;
        end
        pos_row = r;
        pos_col = c;
    endfunction

    // prediction on sample and register transfers, checking on result transfers
    always @(posedge i_clk) begin
        t_cell_res want;
        if (!i_rst_n) begin
            side_reg = t_side'(SIDE_RST);
            pos_row  = 0;
            pos_col  = 0;
        end else begin
            if (i_cfg_we) begin
                side_reg = i_cfg_wdata;
                pos_row  = 0;
                pos_col  = 0;
            end
            if (smp_if.valid && smp_if.ready) begin
                predict_cell_sums(smp_if.sample, cur_typed, cur_typed_sum);
            end
            if (res_if.valid && res_if.ready) begin
                if (expected_cells.size() == 0) begin
                    $error("unexpected result: row %0d col %0d sum %0d",
                           res_if.cell_row, res_if.cell_col, res_if.neighbour_sum);
                    err_count++;
                end else begin
                    want = expected_cells.pop_front();
                    if (res_if.neighbour_sum !== want.nsum) begin
                        $error("neighbour_sum: expected %0d, got %0d",
                               want.nsum, res_if.neighbour_sum);
                        err_count++;
                    end
                    if (res_if.cell_row !== want.row) begin
                        $error("cell_row: expected %0d, got %0d", want.row, res_if.cell_row);
                        err_count++;
                    end
                    if (res_if.cell_col !== want.col) begin
                        $error("cell_col: expected %0d, got %0d", want.col, res_if.cell_col);
                        err_count++;
                    end
                    if (res_if.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, got %0b",
                               want.run_last, res_if.run_last);
                        err_count++;
                    end
                    if (res_if.frame_done !== want.frame_done) begin
                        $error("frame_done: expected %0b, got %0b",
                               want.frame_done, res_if.frame_done);
                        err_count++;
                    end
                end
            end
        end
    end

    // watchdog: cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result sink: random stall per transfer, one long hold-off on request
    initial begin
        int stall;
        res_if.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            @(negedge i_clk);
        end
    end

    task automatic send_sample(t_sample v, bit typed, int tsum);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        @(negedge i_clk);
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        smp_if.valid  <= 1'b1;
        smp_if.sample <= v;
        cur_typed     <= typed;
        cur_typed_sum <= tsum;
        do @(posedge i_clk); while (!smp_if.ready);
    endtask

    // register writes only once the block has drained
    task automatic write_side(int v);
        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (expected_cells.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= t_side'(v);
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        drv_side = clamp_side(v);
    endtask

    task automatic send_random_frame(int count);
        int v;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 7))
                0:       v = 32767;
                1:       v = -32768;
                default: v = $urandom_range(0, 65535);
            endcase
            send_sample(t_sample'(v), 1'b0, 0);
        end
    endtask

    initial begin
        int sent;
        int area;
        int count;
        int pick;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        smp_if.valid  = 1'b0;
        smp_if.sample = '0;
        cur_typed     = 1'b0;
        cur_typed_sum = 0;
        calm          = 1'b0;
        hold_req      = 1'b0;
        err_count     = 0;
        idle_cycles   = 0;
        drv_side      = SIDE_RST;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < MAX_SIDE; c++) window_rows[r][c] = '0;
        end

        // uniform side-2 frames (each cell sums the other three), then side-3 frames
        plan = '{
            '{STEP_SMP,  32767, 1, 1'b0,      0},
            '{STEP_CFG,      2, 1, 1'b0,      0},
            '{STEP_SMP,  32767, 3, 1'b0,      0},
            '{STEP_SMP,  32767, 1, 1'b1,  98301},
            '{STEP_CFG,      0, 1, 1'b0,      0},
            '{STEP_SMP, -32768, 3, 1'b0,      0},
            '{STEP_SMP, -32768, 1, 1'b1, -98304},
            '{STEP_CFG,     63, 1, 1'b0,      0},
            '{STEP_SMP,   4660, 1, 1'b0,      0},
            '{STEP_CFG,      3, 1, 1'b0,      0},
            '{STEP_SMP,  32767, 9, 1'b0,      0},
            '{STEP_SMP, -32768, 9, 1'b0,      0}
        };

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == STEP_CFG) begin
                write_side(plan[i].value);
            end else begin
                repeat (plan[i].reps) begin
                    send_sample(t_sample'(plan[i].value), plan[i].typed, plan[i].exp_sum);
                end
            end
        end

        // three rows at the largest side, with the sink held off early on
        write_side(MAX_SIDE);
        hold_req = 1'b1;
        send_random_frame(3 * MAX_SIDE);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) begin
                pick = $urandom_range(0, 9);
                if (pick == 0) begin
                    write_side($urandom_range(0, 1));
                end else if (pick == 1) begin
                    write_side($urandom_range(MAX_SIDE + 1, 63));
                end else begin
                    write_side($urandom_range(2, 9));
                end
            end
            area  = (drv_side > 9) ? 81 : drv_side * drv_side;
            count = ($urandom_range(0, 4) == 0) ? $urandom_range(1, area - 1) : area;
            send_random_frame(count);
            sent += count;
        end

        @(negedge i_clk);
        smp_if.valid <= 1'b0;
        while (expected_cells.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== neighbour_sum_3x3.f =====
hw/rtl/ns3_pkg.sv
hw/rtl/ns3_in_if.sv
hw/rtl/ns3_out_if.sv
hw/rtl/neighbour_sum_3x3.sv
hw/rtl/ns3_chk.sv
tb/tb_neighbour_sum_3x3.sv
